// ----- src/seven_segment_scan_driver_unit_assert.svh -----
// Assertion helpers for the scan driver.
`ifndef SEVEN_SEGMENT_SCAN_DRIVER_UNIT_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_DRIVER_UNIT_ASSERT_SVH

// Checked only while out of reset.
`define SSDU_ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define SSDU_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/ssd_pkg.sv -----
package ssd_pkg;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_TICK = 1'b1
  } req_t;

  localparam int unsigned NUM_POS         = 4;
  localparam int unsigned POS_W           = 2;
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // shift steps 0..7, then the latch step
  localparam logic [3:0] LATCH_STEP = 4'd8;

  localparam logic [7:0] DP_BIT = 8'h80;

  // decimal point codes for positions 0..2
  localparam logic [2:0] DP_ON_POS0 = 3'd2;
  localparam logic [2:0] DP_ON_POS1 = 3'd3;
  localparam logic [2:0] DP_ON_POS2 = 3'd4;

  // floor(n / 10) = (n * RECIP10) >> 19 for n < 65536
  localparam logic [15:0] RECIP10       = 16'd52429;
  localparam int unsigned RECIP10_SHIFT = 19;
  // floor(n / 10) = (n * RECIP10_S) >> 11 for n < 1024
  localparam logic [7:0]  RECIP10_S       = 8'd205;
  localparam int unsigned RECIP10_S_SHIFT = 11;

  typedef struct packed {
    logic [7:0]       pattern;
    logic [POS_W-1:0] pos;
  } tick_cmd_t;

  function automatic logic [7:0] digit_seg(input logic [3:0] d);
    logic [7:0] s;
    unique case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h67;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] unit_seg(input logic [1:0] code);
    logic [7:0] s;
    unique case (code)
      2'd0:    s = 8'h3E;
      2'd1:    s = 8'h39;
      2'd2:    s = 8'h73;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

endpackage

// ----- src/ssd_front.sv -----
module ssd_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  ssd_pkg::req_t           req,
  input  logic [15:0]             number,
  input  logic [2:0]              dot_sel,
  input  logic [1:0]              letter,
  input  logic                    q_full,
  output logic                    push,
  output ssd_pkg::tick_cmd_t      cmd
);

  // stage 1: input word
  logic                s1_valid_r;
  ssd_pkg::req_t       s1_req_r;
  logic [15:0]         s1_num_r;
  logic [2:0]          s1_dp_r;
  logic [1:0]          s1_let_r;
  // stage 2: units digit split off
  logic                s2_valid_r;
  ssd_pkg::req_t       s2_req_r;
  logic [12:0]         s2_q1_r;
  logic [3:0]          s2_d0_r;
  logic [2:0]          s2_dp_r;
  logic [1:0]          s2_let_r;
  // stage 3: tens digit split off; table and scan state live here
  logic                s3_valid_r;
  ssd_pkg::req_t       s3_req_r;
  logic [9:0]          s3_q2_r;
  logic [3:0]          s3_d1_r;
  logic [3:0]          s3_d0_r;
  logic [2:0]          s3_dp_r;
  logic [1:0]          s3_let_r;

  logic [7:0]                  pat_r [ssd_pkg::NUM_POS];
  logic [ssd_pkg::POS_W-1:0]   scan_r;

  logic        adv;
  logic [31:0] prod1;
  logic [12:0] q1;
  logic [3:0]  d0;
  logic [28:0] prod2;
  logic [9:0]  q2;
  logic [3:0]  d1;
  logic [17:0] prod3;
  logic [6:0]  q3;
  logic [3:0]  d2;
  logic        s3_tick;

  assign s3_tick  = (s3_req_r == ssd_pkg::REQ_TICK);
  assign adv      = !(s3_valid_r && s3_tick && q_full);
  assign in_ready = adv;
  assign push     = s3_valid_r && s3_tick && !q_full;
  assign cmd.pattern = pat_r[scan_r];
  assign cmd.pos     = scan_r;

  always_comb begin
    prod1 = 32'(s1_num_r) * 32'(ssd_pkg::RECIP10);
    q1    = prod1[ssd_pkg::RECIP10_SHIFT +: 13];
    d0    = 4'(s1_num_r - 16'(q1) * 16'd10);
    prod2 = 29'(s2_q1_r) * 29'(ssd_pkg::RECIP10);
    q2    = prod2[ssd_pkg::RECIP10_SHIFT +: 10];
    d1    = 4'(s2_q1_r - 13'(q2) * 13'd10);
    prod3 = 18'(s3_q2_r) * 18'(ssd_pkg::RECIP10_S);
    q3    = prod3[ssd_pkg::RECIP10_S_SHIFT +: 7];
    d2    = 4'(s3_q2_r - 10'(q3) * 10'd10);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= in_valid;
      s2_valid_r <= s1_valid_r;
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_req_r <= req;
      s1_num_r <= number;
      s1_dp_r  <= dot_sel;
      s1_let_r <= letter;
      s2_req_r <= s1_req_r;
      s2_q1_r  <= q1;
      s2_d0_r  <= d0;
      s2_dp_r  <= s1_dp_r;
      s2_let_r <= s1_let_r;
      s3_req_r <= s2_req_r;
      s3_q2_r  <= q2;
      s3_d1_r  <= d1;
      s3_d0_r  <= s2_d0_r;
      s3_dp_r  <= s2_dp_r;
      s3_let_r <= s2_let_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ssd_pkg::NUM_POS; i++) pat_r[i] <= 8'h00;
      scan_r <= '0;
    end else if (s3_valid_r && adv) begin
      if (s3_tick) begin
        scan_r <= scan_r + 1'b1;
      end else begin
        // hundreds on position 0, units on position 2
        pat_r[0] <= ssd_pkg::digit_seg(d2) |
                    ((s3_dp_r == ssd_pkg::DP_ON_POS0) ? ssd_pkg::DP_BIT : 8'h00);
        pat_r[1] <= ssd_pkg::digit_seg(s3_d1_r) |
                    ((s3_dp_r == ssd_pkg::DP_ON_POS1) ? ssd_pkg::DP_BIT : 8'h00);
        pat_r[2] <= ssd_pkg::digit_seg(s3_d0_r) |
                    ((s3_dp_r == ssd_pkg::DP_ON_POS2) ? ssd_pkg::DP_BIT : 8'h00);
        pat_r[3] <= ssd_pkg::unit_seg(s3_let_r);
      end
    end
  end

endmodule

// ----- src/ssd_fifo.sv -----
module ssd_fifo #(
  parameter int unsigned DEPTH = ssd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  ssd_pkg::tick_cmd_t wr_cmd,
  input  logic               pop,
  output ssd_pkg::tick_cmd_t rd_cmd,
  output logic               full,
  output logic               empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ssd_pkg::tick_cmd_t mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r;
  logic [PTR_W-1:0]   rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;

  assign full   = (cnt_r == CNT_W'(DEPTH));
  assign empty  = (cnt_r == '0);
  assign rd_cmd = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wr_cmd;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ----- src/ssd_back.sv -----
module ssd_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      q_empty,
  input  ssd_pkg::tick_cmd_t        q_cmd,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      serial_bit,
  output logic                      is_latch,
  output logic [3:0]                digit_enable_n,
  output logic                      last
);

  logic                        busy_r;
  logic [7:0]                  byte_r;
  logic [ssd_pkg::POS_W-1:0]   pos_r;
  logic [3:0]                  cnt_r;

  assign is_latch       = (cnt_r == ssd_pkg::LATCH_STEP);
  assign out_valid      = busy_r;
  assign serial_bit     = is_latch ? 1'b0 : byte_r[7];
  assign digit_enable_n = is_latch ? 4'(~(4'b0001 << pos_r)) : 4'hF;
  assign last           = is_latch;
  // next tick starts straight after the latch word goes out
  assign pop = !q_empty && (!busy_r || (out_ready && is_latch));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r && out_ready) begin
      if (is_latch) busy_r <= 1'b0;
      else          cnt_r  <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      byte_r <= q_cmd.pattern;
      pos_r  <= q_cmd.pos;
    end else if (busy_r && out_ready && !is_latch) begin
      byte_r <= {byte_r[6:0], 1'b0};
    end
  end

endmodule

// ----- src/seven_segment_scan_driver_unit.sv -----
// The first word of a tick appears once the tick has passed the front stages and the queue.
// Throughput: a tick gives 9 words, one per cycle while out_tready is high;
// a load gives none. The serializer sets the rate.
// A 3-stage front splits the digits and may run up to QUEUE_DEPTH + 3 ticks ahead.
// Reset (synchronous, active low) blanks all positions and restarts the scan.
module seven_segment_scan_driver_unit #(
  parameter int unsigned QUEUE_DEPTH = ssd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // number[15:0], dot_sel[18:16], letter[20:19]
  input  logic [0:0]  in_tuser,   // req_type[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // serial_bit[0], digit_enable_n[4:1]
  output logic [0:0]  out_tuser,  // is_latch[0]
  output logic        out_tlast
);

  `include "seven_segment_scan_driver_unit_assert.svh"

  logic               push;
  logic               pop;
  logic               q_full;
  logic               q_empty;
  ssd_pkg::tick_cmd_t wr_cmd;
  ssd_pkg::tick_cmd_t rd_cmd;
  logic               serial_bit;
  logic               is_latch;
  logic [3:0]         digit_enable_n;
  logic               latch_ok;
  logic               shift_ok;

  ssd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .req         (ssd_pkg::req_t'(in_tuser[0])),
    .number      (in_tdata[15:0]),
    .dot_sel     (in_tdata[18:16]),
    .letter      (in_tdata[20:19]),
    .q_full      (q_full),
    .push        (push),
    .cmd         (wr_cmd)
  );

  ssd_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wr_cmd (wr_cmd),
    .pop    (pop),
    .rd_cmd (rd_cmd),
    .full   (q_full),
    .empty  (q_empty)
  );

  ssd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_cmd          (rd_cmd),
    .pop            (pop),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .serial_bit     (serial_bit),
    .is_latch       (is_latch),
    .digit_enable_n (digit_enable_n),
    .last           (out_tlast)
  );

  assign out_tdata    = {3'b000, digit_enable_n, serial_bit};
  assign out_tuser[0] = is_latch;

  assign latch_ok = ($countones(~digit_enable_n) == 1) && !serial_bit;
  assign shift_ok = (digit_enable_n == 4'hF) && !out_tlast;

  `SSDU_ASSERT_CLK(a_latch_one_digit, out_tvalid && is_latch |-> latch_ok, "bad latch word")
  `SSDU_ASSERT_CLK(a_shift_all_off, out_tvalid && !is_latch |-> shift_ok, "bad shift word")
  `SSDU_ASSERT_CLK(a_stall_only_full, !in_tready |-> q_full, "input stalled, queue has room")
  `SSDU_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

// ----- sim/seven_segment_scan_driver_unit_check.sv -----
module segment_stream_check
  import ssd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // number[15:0], dot_sel[18:16], letter[20:19]
  input  logic [0:0]  in_tuser,   // req_type[0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,  // serial_bit[0], digit_enable_n[4:1]
  input  logic [0:0]  out_tuser,  // is_latch[0]
  input  logic        out_tlast,
  output int unsigned words_pending,
  output int unsigned mismatches
);

  typedef struct packed {
    logic       serial_bit;
    logic       is_latch;
    logic [3:0] digit_enable_n;
    logic       last_word;
  } scan_word_t;

  localparam logic [7:0] DIGIT_FONT [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h67
  };
  localparam logic [7:0] UNIT_FONT [4] = '{8'h3E, 8'h39, 8'h73, 8'h00};

  logic [7:0]       seg_bytes [NUM_POS];
  logic [POS_W-1:0] scan_pos;
  scan_word_t       shift_words [$];

  initial mismatches = 0;
  initial words_pending = 0;

  function automatic void show_number(input logic [15:0] num, input logic [2:0] dp,
                                      input logic [1:0] unit_code);
    int unsigned shown;
    shown = num % 1000;
    seg_bytes[0] = DIGIT_FONT[shown / 100];
    seg_bytes[1] = DIGIT_FONT[(shown / 10) % 10];
    seg_bytes[2] = DIGIT_FONT[shown % 10];
    if (dp >= DP_ON_POS0 && dp <= DP_ON_POS2) begin
      seg_bytes[dp - DP_ON_POS0] = seg_bytes[dp - DP_ON_POS0] | DP_BIT;
    end
    seg_bytes[3] = UNIT_FONT[unit_code];
  endfunction

  // MSB first, then the latch word enabling the current digit
  function automatic void queue_refresh();
    logic [7:0] pattern;
    scan_word_t w;
    pattern = seg_bytes[scan_pos];
    for (int i = 7; i >= 0; i--) begin
      w = '{serial_bit: pattern[i], is_latch: 1'b0, digit_enable_n: 4'hF, last_word: 1'b0};
      shift_words.push_back(w);
    end
    w = '{serial_bit: 1'b0, is_latch: 1'b1,
          digit_enable_n: ~(4'b0001 << scan_pos), last_word: 1'b1};
    shift_words.push_back(w);
    scan_pos = scan_pos + 1'b1;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned seen);
    if (want != seen) begin
      $error("%s: expected %0h, got %0h", name, want, seen);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    scan_word_t want;
    if (!rst_n) begin
      for (int p = 0; p < NUM_POS; p++) seg_bytes[p] = 8'h00;
      scan_pos = '0;
      shift_words.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (shift_words.size() == 0) begin
          $error("word with none expected: tdata %0h tuser %0h tlast %0b",
                 out_tdata, out_tuser, out_tlast);
          mismatches++;
        end else begin
          want = shift_words.pop_front();
          check_field("serial_bit", want.serial_bit, out_tdata[0]);
          check_field("digit_enable_n", want.digit_enable_n, out_tdata[4:1]);
          check_field("tdata_pad", 0, out_tdata[7:5]);
          check_field("is_latch", want.is_latch, out_tuser[0]);
          check_field("last", want.last_word, out_tlast);
        end
      end
      if (in_tvalid && in_tready) begin
        if (req_t'(in_tuser[0]) == REQ_TICK) queue_refresh();
        else show_number(in_tdata[15:0], in_tdata[18:16], in_tdata[20:19]);
      end
    end
    words_pending <= shift_words.size();
  end

endmodule

// ----- sim/seven_segment_scan_driver_unit_tb.sv -----
module seven_segment_scan_driver_unit_tb;
  import ssd_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;   // number[15:0], dot_sel[18:16], letter[20:19]
  logic [0:0]  in_tuser = '0;   // req_type[0]
  logic        out_tvalid;
  logic        out_tready = 1'b1;
  logic [7:0]  out_tdata;       // serial_bit[0], digit_enable_n[4:1]
  logic [0:0]  out_tuser;       // is_latch[0]
  logic        out_tlast;

  int unsigned words_pending;
  int unsigned mismatches;
  logic        quiet_tail = 1'b0;
  int unsigned stall_left = 0;

  seven_segment_scan_driver_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  segment_stream_check scan_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .words_pending (words_pending),
    .mismatches    (mismatches)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // receiver backpressure in bursts
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= (stall_left == 1);
    end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(1, 14);
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_word(input req_t kind, input logic [15:0] num,
                           input logic [2:0] dp, input logic [1:0] unit_code);
    int unsigned gap;
    if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 14);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, unit_code, dp, num};
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_display();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
  endtask

  task automatic refresh_n(input int unsigned n);
    repeat (n) send_word(REQ_TICK, 16'($urandom), 3'($urandom), 2'($urandom));
  endtask

  initial begin
    logic [15:0] num;
    req_t        kind;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // blank display after reset, then digits, decimal point codes, letters
    refresh_n(1);
    send_word(REQ_LOAD, 16'd0, DP_ON_POS0, 2'd0);
    refresh_n(4);
    send_word(REQ_LOAD, 16'hFFFF, DP_ON_POS1, 2'd1);
    refresh_n(5);
    send_word(REQ_LOAD, 16'd999, DP_ON_POS2, 2'd2);
    send_word(REQ_LOAD, 16'd1000, 3'd7, 2'd3);
    refresh_n(4);
    send_word(REQ_LOAD, 16'd12345, 3'd1, 2'd0);
    refresh_n(1);
    send_word(REQ_LOAD, 16'd7, 3'd5, 2'd1);
    refresh_n(1);
    send_word(REQ_LOAD, 16'd880, 3'd6, 2'd2);
    refresh_n(2);

    for (int i = 0; i < 370; i++) begin
      if (i == 310) quiet_tail <= 1'b1;
      if (i == 120 || i == 240) drain_display();
      kind = ($urandom_range(0, 99) < 35) ? REQ_LOAD : REQ_TICK;
      case ($urandom_range(0, 7))
        0, 1:    num = 16'($urandom_range(0, 999));
        2:       num = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'd1000;
        default: num = 16'($urandom);
      endcase
      send_word(kind, num, 3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)));
    end

    drain_display();
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/ssd_pkg.sv
src/ssd_front.sv
src/ssd_fifo.sv
src/ssd_back.sv
src/seven_segment_scan_driver_unit.sv
sim/seven_segment_scan_driver_unit_check.sv
sim/seven_segment_scan_driver_unit_tb.sv
